FILE: hdl/cpg_pkg.sv
// Shared constants and types of the checkerboard pixel generator.
package cpg_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int MAX_CHECK_DEF  = 4096;

	localparam int CHECK_SIZE_W = 13;
	localparam int COUNT_W      = 3;
	localparam int COLOUR_W     = 32;
	localparam int CHAN_NUM     = 4;
	localparam int CFG_IDX_W    = 3;

	localparam logic [CFG_IDX_W-1:0] REG_CHECK_SIZE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIANGLE_MODE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOUR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOUR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd4;

	localparam logic [CHECK_SIZE_W-1:0] CHECK_SIZE_RST    = 13'd10;
	localparam logic [COUNT_W-1:0]      CHANNEL_COUNT_RST = 3'd4;

	typedef struct packed {
		logic [CHECK_SIZE_W-1:0] check_size;
		logic                    triangle_mode;
	} cpg_cfg_t;

	typedef struct packed {
		logic valid;
		logic is_fore;
	} cpg_res_t;

endpackage

FILE: hdl/cpg_engine.sv
// Sequencer and shared subtractor that decide whether a pixel is foreground.
module cpg_engine import cpg_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int MAX_CHECK  = MAX_CHECK_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [COORD_BITS-1:0] pos_x,
	input  logic [COORD_BITS-1:0] pos_y,
	input  cpg_cfg_t              cfg,
	output logic                  ready,
	input  logic                  take,
	output cpg_res_t              res
);

	localparam int SB     = $clog2(MAX_CHECK + 1);
	localparam int DW     = 2 * SB;
	localparam int NW     = 2 * SB + 4;
	localparam int UW     = NW;
	localparam int SQ_IT  = NW / 2;
	localparam int IT_MAX = (COORD_BITS > SQ_IT) ? COORD_BITS : SQ_IT;
	localparam int CTW    = $clog2(IT_MAX);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_SETUP,
		S_DIV,
		S_FOLD1,
		S_FOLD2,
		S_SQRT,
		S_NEXT,
		S_DONE
	} state_t;

	state_t                st_q;
	logic [COORD_BITS-1:0] p_q;
	logic [COORD_BITS-1:0] y_q;
	logic                  sel_y_q;
	logic                  mode_q;
	logic                  fore_q;
	logic [SB-1:0]         ts_q;
	logic [DW-1:0]         sq_q;
	logic [DW-1:0]         d_q;
	logic [DW-1:0]         half_q;
	logic [DW-1:0]         rem_q;
	logic [NW-1:0]         op_q;
	logic [NW-1:0]         root_q;
	logic [NW-1:0]         one_q;
	logic [CTW-1:0]        cnt_q;

	logic [SB-1:0] size_eff;
	logic [SB-1:0] size_tri;
	logic [DW:0]   rem_sh;
	logic [UW-1:0] sub_a;
	logic [UW-1:0] sub_b;
	logic [UW:0]   diff;
	logic          borrow;
	logic [NW-1:0] root_nx;

	always_comb begin
		if (cfg.check_size == '0) begin
			size_eff = SB'(1);
		end else if (32'(cfg.check_size) > 32'(MAX_CHECK)) begin
			size_eff = SB'(MAX_CHECK);
		end else begin
			size_eff = SB'(cfg.check_size);
		end
		size_tri = (size_eff == SB'(1)) ? SB'(2) : size_eff;
	end

	assign rem_sh = {rem_q, p_q[COORD_BITS-1]};

	// The shared subtractor of the block, used by division, folding and square root.
	always_comb begin
		case (st_q)
			S_DIV: begin
				sub_a = UW'(rem_sh);
				sub_b = UW'(d_q);
			end
			S_FOLD1: begin
				sub_a = UW'(rem_q);
				sub_b = UW'(half_q);
			end
			S_FOLD2: begin
				sub_a = UW'(d_q);
				sub_b = UW'(rem_q);
			end
			S_SQRT: begin
				sub_a = op_q;
				sub_b = root_q | one_q;
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
	end

	assign diff    = {1'b0, sub_a} - {1'b0, sub_b};
	assign borrow  = diff[UW];
	assign root_nx = borrow ? (root_q >> 1) : ((root_q >> 1) | one_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			sel_y_q <= 1'b0;
			mode_q  <= 1'b0;
			fore_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (start) begin
						p_q     <= pos_x;
						y_q     <= pos_y;
						sel_y_q <= 1'b0;
						fore_q  <= 1'b0;
						mode_q  <= cfg.triangle_mode;
						ts_q    <= size_tri;
						rem_q   <= '0;
						cnt_q   <= CTW'(COORD_BITS - 1);
						if (cfg.triangle_mode) begin
							st_q <= S_MUL;
						end else begin
							d_q  <= DW'(size_eff);
							st_q <= S_DIV;
						end
					end
				end
				S_MUL: begin
					sq_q <= DW'(ts_q) * DW'(ts_q);
					st_q <= S_SETUP;
				end
				S_SETUP: begin
					d_q    <= sq_q - DW'(1);
					half_q <= (sq_q + DW'(ts_q)) >> 1;
					st_q   <= S_DIV;
				end
				S_DIV: begin
					rem_q <= borrow ? rem_sh[DW-1:0] : diff[DW-1:0];
					p_q   <= p_q << 1;
					cnt_q <= cnt_q - CTW'(1);
					if (cnt_q == '0) begin
						if (mode_q) begin
							st_q <= S_FOLD1;
						end else begin
							fore_q <= fore_q ^ !borrow;
							st_q   <= S_NEXT;
						end
					end
				end
				S_FOLD1: begin
					root_q <= '0;
					one_q  <= NW'(1) << (NW - 2);
					cnt_q  <= CTW'(SQ_IT - 1);
					if (borrow) begin
						op_q <= NW'({rem_q, 3'b001});
						st_q <= S_SQRT;
					end else begin
						st_q <= S_FOLD2;
					end
				end
				S_FOLD2: begin
					op_q <= NW'({diff[DW-1:0], 3'b001});
					st_q <= S_SQRT;
				end
				S_SQRT: begin
					if (!borrow) begin
						op_q <= diff[NW-1:0];
					end
					root_q <= root_nx;
					one_q  <= one_q >> 2;
					cnt_q  <= cnt_q - CTW'(1);
					if (cnt_q == '0) begin
						fore_q <= fore_q ^ root_nx[1] ^ root_nx[0];
						st_q   <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (sel_y_q) begin
						st_q <= S_DONE;
					end else begin
						p_q     <= y_q;
						sel_y_q <= 1'b1;
						rem_q   <= '0;
						cnt_q   <= CTW'(COORD_BITS - 1);
						st_q    <= S_DIV;
					end
				end
				S_DONE: begin
					if (take) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign ready       = (st_q == S_IDLE);
	assign res.valid   = (st_q == S_DONE);
	assign res.is_fore = fore_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_DIV |-> rem_q < d_q)
		else $error("Remainder is not below the divisor during division.");

	a_root_bit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_SQRT |-> $onehot(one_q))
		else $error("Square root trial bit is not one-hot.");

	a_sqrt_only_triangle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_SQRT || st_q == S_FOLD1 || st_q == S_FOLD2) |-> mode_q)
		else $error("Run search entered in regular mode.");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !take |=> res.valid && $stable(fore_q))
		else $error("Finished result was lost before it was taken.");

	a_start_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && ready |=> !ready && !res.valid)
		else $error("Accepted request did not start the sequencer.");

endmodule

FILE: hdl/checkerboard_pixel_generator_core.sv
// Top level of the checkerboard pixel generator: channels, registers and output stage.
//
// Each request on the slave stream carries one pixel coordinate, pos_x in the low
// COORD_BITS of s_tdata and pos_y above it. The master stream returns one result per
// request: is_fore in m_tuser and the four channel bytes in m_tdata, channel 0 lowest,
// with bytes at or above channel_count forced to zero.
// Registers are written on the cfg channel (index 0 check_size, 1 triangle_mode,
// 2 fore_colour, 3 back_colour, 4 channel_count); higher indexes are ignored, and
// cfg_ready is always high. Write them only while no request is in flight.
// One request at a time goes through a sequencer around a shared subtractor.
// Regular mode: two restoring divisions of COORD_BITS steps each. Triangular mode adds
// a multiply and a setup step for the period, and per coordinate a fold of one or two
// steps and a square root of $clog2(MAX_CHECK+1)+2 steps.
// s_tready is high only while the sequencer is idle. The finished result moves into
// an output register, so a new request is taken while an earlier result still waits.
// If the receiver stalls with that register full, the sequencer holds its result.
// Reset clears the sequencer and the output valid and loads the register defaults.
module checkerboard_pixel_generator_core import cpg_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int MAX_CHECK  = MAX_CHECK_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// Fields from bit 0 up: pos_x, pos_y, zero padding.
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// Fields from bit 0 up: chan0, chan1, chan2, chan3.
	output logic [CHAN_NUM*8-1:0]                 m_tdata,
	// Fields from bit 0 up: is_fore.
	output logic                                  m_tuser,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]                  cfg_index,
	input  logic [COLOUR_W-1:0]                   cfg_data
);

	logic [CHECK_SIZE_W-1:0] check_size_q;
	logic                    triangle_mode_q;
	logic [COLOUR_W-1:0]     fore_colour_q;
	logic [COLOUR_W-1:0]     back_colour_q;
	logic [COUNT_W-1:0]      channel_count_q;

	logic                 m_tvalid_q;
	logic                 is_fore_q;
	logic [CHAN_NUM*8-1:0] chan_q;

	cpg_cfg_t            cfg;
	cpg_res_t            res;
	logic                eng_ready;
	logic                take;
	logic [COLOUR_W-1:0] colour;
	logic [CHAN_NUM*8-1:0] chan_nx;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_size_q    <= CHECK_SIZE_RST;
			triangle_mode_q <= 1'b0;
			fore_colour_q   <= '0;
			back_colour_q   <= '0;
			channel_count_q <= CHANNEL_COUNT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CHECK_SIZE:    check_size_q    <= cfg_data[CHECK_SIZE_W-1:0];
				REG_TRIANGLE_MODE: triangle_mode_q <= cfg_data[0];
				REG_FORE_COLOUR:   fore_colour_q   <= cfg_data;
				REG_BACK_COLOUR:   back_colour_q   <= cfg_data;
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.check_size    = check_size_q;
	assign cfg.triangle_mode = triangle_mode_q;

	assign take = !m_tvalid_q || m_tready;

	cpg_engine #(
		.COORD_BITS(COORD_BITS),
		.MAX_CHECK (MAX_CHECK)
	) u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.start (s_tvalid && eng_ready),
		.pos_x (s_tdata[COORD_BITS-1:0]),
		.pos_y (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.cfg   (cfg),
		.ready (eng_ready),
		.take  (take),
		.res   (res)
	);

	assign s_tready = eng_ready;

	// A channel count above four uses all four bytes.
	always_comb begin
		colour = res.is_fore ? fore_colour_q : back_colour_q;
		for (int k = 0; k < CHAN_NUM; k++) begin
			chan_nx[8*k +: 8] = (32'(channel_count_q) > k) ? colour[8*k +: 8] : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (take) begin
			m_tvalid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res.valid) begin
			is_fore_q <= res.is_fore;
			chan_q    <= chan_nx;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = chan_q;
	assign m_tuser  = is_fore_q;

endmodule

FILE: verif/tb.sv
// Testbench of the checkerboard pixel generator: directed, random and back-pressure tests.
module tb import cpg_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW           = COORD_BITS_DEF;
	localparam int SIZE_CAP     = MAX_CHECK_DEF;
	localparam int SDATA_W      = ((2*CW+7)/8)*8;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int TAIL_CYCLES  = 100;
	localparam int HOLD_CYCLES  = 800;
	localparam int PRINT_CAP    = 40;
	localparam int PHASE_ITEMS  = 300;
	localparam int PHASE_BLOCKS = 6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_CHANNEL_COUNT + 1'b1;

	typedef struct packed {
		logic [CW-1:0]         x;
		logic [CW-1:0]         y;
		logic                  is_fore;
		logic [CHAN_NUM*8-1:0] chans;
	} pixel_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic [SDATA_W-1:0]     s_tdata   = '0;
	logic                   m_tready  = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [COLOUR_W-1:0]    cfg_data  = '0;
	logic                   s_tready;
	logic                   m_tvalid;
	logic [CHAN_NUM*8-1:0]  m_tdata;
	logic                   m_tuser;
	logic                   cfg_ready;

	logic [CHECK_SIZE_W-1:0] cur_size;
	logic                    cur_tri;
	logic [COLOUR_W-1:0]     cur_fore;
	logic [COLOUR_W-1:0]     cur_back;
	logic [COUNT_W-1:0]      cur_count;

	pixel_t pending_pixels[$];
	int     fail_count     = 0;
	int     cycle_count    = 0;
	int     send_idle_pct  = 0;
	int     recv_stall_pct = 0;
	int     hold_left      = 0;

	checkerboard_pixel_generator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic run_parity(longint unsigned p, longint unsigned s);
		longint unsigned period;
		longint unsigned idx;
		longint unsigned len;
		longint unsigned run;
		bit              rising;
		period = s * s - 1;
		idx    = p % period;
		len    = 1;
		run    = 0;
		rising = 1'b1;
		while (idx >= len) begin
			idx -= len;
			run++;
			if (rising && len < s) begin
				len++;
			end else begin
				rising = 1'b0;
				len--;
			end
			if (len == 0)
				break;
		end
		return ~run[0];
	endfunction

	function automatic pixel_t predict_pixel(logic [CW-1:0] x, logic [CW-1:0] y);
		pixel_t              px;
		longint unsigned     s;
		longint unsigned     ts;
		int unsigned         count;
		logic [COLOUR_W-1:0] colour;
		int                  k;
		s = cur_size;
		if (s < 1)
			s = 1;
		if (s > SIZE_CAP)
			s = SIZE_CAP;
		if (cur_tri) begin
			ts = (s == 1) ? 2 : s;
			px.is_fore = run_parity(x, ts) != run_parity(y, ts);
		end else begin
			px.is_fore = ((x / s) % 2) != ((y / s) % 2);
		end
		count = (cur_count > CHAN_NUM) ? CHAN_NUM : cur_count;
		colour = px.is_fore ? cur_fore : cur_back;
		px.chans = '0;
		for (k = 0; k < CHAN_NUM; k++)
			if (k < count)
				px.chans[8*k +: 8] = colour[8*k +: 8];
		px.x = x;
		px.y = y;
		return px;
	endfunction

	task automatic report_mismatch(string what);
		fail_count++;
		if (fail_count <= PRINT_CAP)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		pixel_t want;
		int     k;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch($sformatf("result with no request waiting: is_fore %0b data %08h",
					m_tuser, m_tdata));
			end else begin
				want = pending_pixels.pop_front();
				if (m_tuser !== want.is_fore)
					report_mismatch($sformatf("pixel (%0d,%0d) is_fore %0b, expected %0b",
						want.x, want.y, m_tuser, want.is_fore));
				for (k = 0; k < CHAN_NUM; k++)
					if (m_tdata[8*k +: 8] !== want.chans[8*k +: 8])
						report_mismatch($sformatf("pixel (%0d,%0d) chan%0d %02h, expected %02h",
							want.x, want.y, k, m_tdata[8*k +: 8], want.chans[8*k +: 8]));
			end
		end
	end

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOUR_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_CHECK_SIZE:    cur_size  = data[CHECK_SIZE_W-1:0];
			REG_TRIANGLE_MODE: cur_tri   = data[0];
			REG_FORE_COLOUR:   cur_fore  = data;
			REG_BACK_COLOUR:   cur_back  = data;
			REG_CHANNEL_COUNT: cur_count = data[COUNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pixel(input logic [CW-1:0] x, input logic [CW-1:0] y);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= SDATA_W'({y, x});
		do @(posedge clk); while (s_tready !== 1'b1);
		pending_pixels.push_back(predict_pixel(x, y));
	endtask

	// The user must write configuration only with no request in flight; the block does not enforce it.
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [CHECK_SIZE_W-1:0] pick_size();
		case ($urandom_range(9))
			0: return '0;
			1: return 1;
			2: return SIZE_CAP;
			3: return CHECK_SIZE_W'($urandom_range(SIZE_CAP + 1, (1 << CHECK_SIZE_W) - 1));
			4: return CHECK_SIZE_W'($urandom_range(17, SIZE_CAP - 1));
			default: return CHECK_SIZE_W'($urandom_range(2, 16));
		endcase
	endfunction

	function automatic logic [COLOUR_W-1:0] pick_colour();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [CW-1:0] pick_coord();
		if ($urandom_range(3) == 0)
			return CW'($urandom_range(0, 4 * cur_size + 8));
		return CW'($urandom);
	endfunction

	task automatic test_reset_values();
		send_pixel(0, 0);
		send_pixel(10, 0);
		send_pixel(0, 10);
		send_pixel(10, 10);
	endtask

	task automatic test_regular_sizes();
		wait_idle();
		set_reg(REG_FORE_COLOUR, 32'hA5C3_0F81);
		set_reg(REG_BACK_COLOUR, 32'h5A3C_F07E);
		set_reg(REG_CHECK_SIZE, 1);
		send_pixel(0, 0);
		send_pixel(1, 0);
		send_pixel('1, 0);
		send_pixel('1, '1);
		wait_idle();
		set_reg(REG_CHECK_SIZE, 0);
		send_pixel(1, 0);
		wait_idle();
		set_reg(REG_CHECK_SIZE, (1 << CHECK_SIZE_W) - 1);
		send_pixel(SIZE_CAP - 1, SIZE_CAP);
		wait_idle();
		// Bits above the register width must be dropped.
		set_reg(REG_CHECK_SIZE, 32'hFFFF_E000 | (SIZE_CAP + 1));
		send_pixel(SIZE_CAP, 0);
	endtask

	task automatic test_triangular();
		wait_idle();
		set_reg(REG_TRIANGLE_MODE, 1);
		set_reg(REG_CHECK_SIZE, 1);
		send_pixel(0, 1);
		send_pixel(2, '1);
		wait_idle();
		set_reg(REG_CHECK_SIZE, 0);
		send_pixel(1, 2);
		wait_idle();
		set_reg(REG_CHECK_SIZE, 3);
		send_pixel(7, 8);
		send_pixel(5, 0);
		wait_idle();
		set_reg(REG_CHECK_SIZE, SIZE_CAP);
		send_pixel('1, 0);
		send_pixel(SIZE_CAP, 8000);
	endtask

	task automatic test_channels();
		wait_idle();
		set_reg(REG_TRIANGLE_MODE, 0);
		set_reg(REG_CHECK_SIZE, 1);
		set_reg(REG_FORE_COLOUR, '1);
		set_reg(REG_BACK_COLOUR, '0);
		set_reg(REG_CHANNEL_COUNT, 0);
		send_pixel(0, 1);
		wait_idle();
		set_reg(REG_CHANNEL_COUNT, 5);
		send_pixel(0, 1);
		wait_idle();
		set_reg(REG_CHANNEL_COUNT, 7);
		send_pixel(1, 1);
		wait_idle();
		set_reg(REG_CHANNEL_COUNT, 1);
		send_pixel(0, 1);
		wait_idle();
		set_reg(REG_CHANNEL_COUNT, 2);
		send_pixel(5, 0);
	endtask

	task automatic test_unused_registers();
		int i;
		wait_idle();
		for (i = 0; i < 3; i++)
			set_reg(CFG_IDX_W'(REG_UNUSED_FIRST + i), '1);
		send_pixel(3, 0);
	endtask

	task automatic shuffle_config(bit all_regs);
		if (all_regs || $urandom_range(1))
			set_reg(REG_CHECK_SIZE, pick_size());
		if (all_regs || $urandom_range(1))
			set_reg(REG_TRIANGLE_MODE, $urandom_range(1));
		if (all_regs || $urandom_range(1))
			set_reg(REG_FORE_COLOUR, pick_colour());
		if (all_regs || $urandom_range(1))
			set_reg(REG_BACK_COLOUR, pick_colour());
		if (all_regs || $urandom_range(1))
			set_reg(REG_CHANNEL_COUNT, $urandom_range(7));
	endtask

	task automatic test_random_phase(int send_pct, int recv_pct);
		int blk;
		int n;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		for (blk = 0; blk < PHASE_BLOCKS; blk++) begin
			wait_idle();
			shuffle_config(blk == 0);
			for (n = 0; n < PHASE_ITEMS / PHASE_BLOCKS; n++)
				send_pixel(pick_coord(), pick_coord());
		end
	endtask

	// The receiver holds off while requests keep coming, so the block fills up.
	task automatic test_backpressure();
		int n;
		wait_idle();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		set_reg(REG_TRIANGLE_MODE, 1);
		set_reg(REG_CHECK_SIZE, 64);
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		for (n = 0; n < 6; n++)
			send_pixel(CW'($urandom), CW'($urandom));
		wait_idle();
	endtask

	initial begin
		cur_size  = CHECK_SIZE_RST;
		cur_tri   = 1'b0;
		cur_fore  = '0;
		cur_back  = '0;
		cur_count = CHANNEL_COUNT_RST;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_regular_sizes();
		test_triangular();
		test_channels();
		test_unused_registers();
		test_random_phase(0, 0);
		test_random_phase(64, 0);
		test_random_phase(0, 64);
		test_random_phase(12, 12);
		test_backpressure();

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_pixels.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_pixels.size()));
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
